// ===== design/qcsd_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, codes and helper functions of the QOI chunk stream decoder.
package qcsd_pkg;

    localparam int INDEX_ENTRIES = 64;
    localparam int IDX_BITS      = $clog2(INDEX_ENTRIES);
    localparam int CFG_IDX_W     = 4;
    localparam int CFG_DATA_W    = 16;
    localparam int POS_W         = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = CFG_IDX_W'(1);

    localparam logic [7:0] QOI_OP_RGB  = 8'hfe;
    localparam logic [7:0] QOI_OP_RGBA = 8'hff;
    localparam logic [1:0] QOI_TAG_INDEX = 2'b00;
    localparam logic [1:0] QOI_TAG_DIFF  = 2'b01;
    localparam logic [1:0] QOI_TAG_LUMA  = 2'b10;
    localparam logic [1:0] QOI_TAG_RUN   = 2'b11;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
    } pixel_t;

    localparam int PIXEL_W = $bits(pixel_t);

    typedef enum logic [1:0] {
        PEND_NONE,
        PEND_RGB,
        PEND_RGBA,
        PEND_LUMA
    } pend_t;

    typedef enum logic [2:0] {
        TAG_RGB,
        TAG_RGBA,
        TAG_INDEX,
        TAG_DIFF,
        TAG_LUMA,
        TAG_RUN
    } tag_t;

    typedef enum logic [3:0] {
        OPB_NONE,
        OPB_DROP,
        OPB_TRUNC,
        OPB_SET_RGB,
        OPB_SET_RGBA,
        OPB_INDEX,
        OPB_DIFF,
        OPB_LUMA_TAG,
        OPB_LUMA_DATA,
        OPB_LIT_DATA,
        OPB_RUN
    } byte_op_t;

    typedef enum logic [1:0] {
        EMIT_NONE,
        EMIT_STORE,
        EMIT_RUN,
        EMIT_TRUNC
    } emit_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INDEX,
        ST_STORE,
        ST_RUN,
        ST_TRUNC
    } state_t;

    typedef struct packed {
        logic     accept;
        byte_op_t byte_op;
        logic     load_index;
        emit_t    emit;
    } ctl_cmd_t;

    typedef struct packed {
        logic  beat_valid;
        logic  eod;
        tag_t  tag;
        pend_t pending;
        logic  lit_done;
        logic  image_done;
        logic  dims_zero;
        logic  out_free;
        logic  run_last;
        logic  pix_last;
    } dp_status_t;

    function automatic logic [IDX_BITS-1:0] hash_slot(input pixel_t p);
        logic [11:0] h;
        h = 12'(p.red) * 12'd3 + 12'(p.green) * 12'd5 + 12'(p.blue) * 12'd7
            + 12'(p.alpha) * 12'd11;
        return h[IDX_BITS-1:0];
    endfunction

    function automatic tag_t classify(input logic [7:0] b);
        tag_t t;
        priority if (b == QOI_OP_RGB) t = TAG_RGB;
        else if (b == QOI_OP_RGBA) t = TAG_RGBA;
        else if (b[7:6] == QOI_TAG_INDEX) t = TAG_INDEX;
        else if (b[7:6] == QOI_TAG_DIFF) t = TAG_DIFF;
        else if (b[7:6] == QOI_TAG_LUMA) t = TAG_LUMA;
        else t = TAG_RUN;
        return t;
    endfunction

endpackage

// ===== design/qcsd_if.sv =====
`timescale 1ns / 1ps
// Stream and configuration channel interfaces of the QOI chunk stream decoder.
interface qcsd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       end_of_data;

    modport source (output valid, output data_byte, output end_of_data, input ready);
    modport sink (input valid, input data_byte, input end_of_data, output ready);
endinterface

interface qcsd_out_if;
    logic        valid;
    logic        ready;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [7:0]  alpha;
    logic [15:0] col_pos;
    logic [15:0] row_pos;
    logic        image_last;
    logic        burst_last;
    logic        status;

    modport source (output valid, output red, output green, output blue, output alpha,
                    output col_pos, output row_pos, output image_last,
                    output burst_last, output status, input ready);
    modport sink (input valid, input red, input green, input blue, input alpha,
                  input col_pos, input row_pos, input image_last,
                  input burst_last, input status, output ready);
endinterface

interface qcsd_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [qcsd_pkg::CFG_IDX_W-1:0]  index;
    logic [qcsd_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

// ===== design/qoi_chunk_stream_decoder_unit.sv =====
`timescale 1ns / 1ps
// The output register loads in ST_STORE once a pixel completes; INDEX passes ST_INDEX first.
// Throughput: one byte per cycle for tag and payload bytes that finish no pixel; a byte that
// finishes a pixel holds the input until ST_STORE has loaded the output register.
// RUN emits its copies from ST_RUN, one pixel per cycle while the output register is free.
// Reset: asynchronous, clears control state, pixel state and the 64 index valid bits at once;
// the index RAM needs no clearing pass, so bytes are accepted as soon as reset is released.
module qoi_chunk_stream_decoder_unit #(
    parameter int DIM_BITS = 16
) (
    input logic        clk,
    input logic        rst_n,
    qcsd_in_if.sink    byte_stream,
    qcsd_out_if.source pixel_stream,
    qcsd_cfg_if.sink   cfg
);
    import qcsd_pkg::*;

    ctl_cmd_t   cmd;
    dp_status_t status;

    qcsd_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .status (status),
        .cmd    (cmd)
    );

    qcsd_datapath #(
        .DIM_BITS (DIM_BITS)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .byte_stream  (byte_stream),
        .pixel_stream (pixel_stream),
        .cfg          (cfg),
        .cmd          (cmd),
        .status       (status)
    );
endmodule

// ===== design/qcsd_ram.sv =====
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
module qcsd_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end
endmodule

// ===== design/qcsd_ctrl.sv =====
`timescale 1ns / 1ps
// Controller state machine: sequences byte intake, index reads and pixel emission.
module qcsd_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  qcsd_pkg::dp_status_t status,
    output qcsd_pkg::ctl_cmd_t   cmd
);
    import qcsd_pkg::*;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        cmd.accept     = 1'b0;
        cmd.byte_op    = OPB_NONE;
        cmd.load_index = 1'b0;
        cmd.emit       = EMIT_NONE;
        unique case (state_reg)
            ST_IDLE:
            begin
                cmd.accept = 1'b1;
                if (status.beat_valid)
                begin
                    priority if (status.image_done || status.dims_zero)
                    begin
                        cmd.byte_op = OPB_DROP;
                    end
                    else if (status.eod)
                    begin
                        cmd.byte_op = OPB_TRUNC;
                        state_next  = ST_TRUNC;
                    end
                    else if (status.pending == PEND_NONE)
                    begin
                        unique case (status.tag)
                            TAG_RGB:  cmd.byte_op = OPB_SET_RGB;
                            TAG_RGBA: cmd.byte_op = OPB_SET_RGBA;
                            TAG_INDEX:
                            begin
                                cmd.byte_op = OPB_INDEX;
                                state_next  = ST_INDEX;
                            end
                            TAG_DIFF:
                            begin
                                cmd.byte_op = OPB_DIFF;
                                state_next  = ST_STORE;
                            end
                            TAG_LUMA: cmd.byte_op = OPB_LUMA_TAG;
                            TAG_RUN:
                            begin
                                cmd.byte_op = OPB_RUN;
                                state_next  = ST_RUN;
                            end
                            default: cmd.byte_op = OPB_DROP;
                        endcase
                    end
                    else if (status.pending == PEND_LUMA)
                    begin
                        cmd.byte_op = OPB_LUMA_DATA;
                        state_next  = ST_STORE;
                    end
                    else
                    begin
                        cmd.byte_op = OPB_LIT_DATA;
                        if (status.lit_done)
                        begin
                            state_next = ST_STORE;
                        end
                    end
                end
            end
            ST_INDEX:
            begin
                cmd.load_index = 1'b1;
                state_next     = ST_STORE;
            end
            ST_STORE:
            begin
                if (status.out_free)
                begin
                    cmd.emit   = EMIT_STORE;
                    state_next = ST_IDLE;
                end
            end
            ST_RUN:
            begin
                if (status.out_free)
                begin
                    cmd.emit = EMIT_RUN;
                    if (status.run_last || status.pix_last)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_TRUNC:
            begin
                if (status.out_free)
                begin
                    cmd.emit   = EMIT_TRUNC;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end
endmodule

// ===== design/qcsd_datapath.sv =====
`timescale 1ns / 1ps
// Datapath: pixel state, hash index, raster counters, size registers and output register.
module qcsd_datapath #(
    parameter int DIM_BITS = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    qcsd_in_if.sink              byte_stream,
    qcsd_out_if.source           pixel_stream,
    qcsd_cfg_if.sink             cfg,
    input  qcsd_pkg::ctl_cmd_t   cmd,
    output qcsd_pkg::dp_status_t status
);
    import qcsd_pkg::*;

    localparam int CMP_W = ((DIM_BITS > POS_W) ? DIM_BITS : POS_W) + 1;

    logic [POS_W-1:0]         width_reg, height_reg;
    pend_t                    pend_reg, pend_next;
    logic [1:0]               taken_reg, taken_next;
    logic [7:0]               luma_reg, luma_next;
    pixel_t                   pix_reg, pix_next;
    logic [DIM_BITS-1:0]      col_reg, col_next, row_reg, row_next;
    logic                     done_reg, done_next;
    logic [5:0]               run_reg, run_next;
    logic [INDEX_ENTRIES-1:0] valid_reg, valid_next;
    logic                     rdv_reg;

    logic                     out_valid_reg, out_valid_next;
    pixel_t                   out_pix_reg, out_pix_next;
    logic [POS_W-1:0]         out_col_reg, out_col_next, out_row_reg, out_row_next;
    logic                     out_ilast_reg, out_ilast_next;
    logic                     out_blast_reg, out_blast_next;
    logic                     out_status_reg, out_status_next;

    logic [CMP_W-1:0]         col_ext, row_ext, col_plus, row_plus;
    logic                     col_end, pix_last;
    logic [IDX_BITS-1:0]      slot;
    logic [PIXEL_W-1:0]       ram_rd;
    logic [7:0]               b;
    logic [5:0]               dg;

    assign b        = byte_stream.data_byte;
    assign dg       = luma_reg[5:0];
    assign slot     = hash_slot(pix_reg);
    assign col_ext  = CMP_W'(col_reg);
    assign row_ext  = CMP_W'(row_reg);
    assign col_plus = col_ext + CMP_W'(1);
    assign row_plus = row_ext + CMP_W'(1);
    assign col_end  = col_plus >= CMP_W'(width_reg);
    assign pix_last = col_end && (row_plus >= CMP_W'(height_reg));

    qcsd_ram #(
        .WIDTH (PIXEL_W),
        .DEPTH (INDEX_ENTRIES)
    ) u_index_ram (
        .clk     (clk),
        .wr_en   (cmd.emit == EMIT_STORE),
        .wr_addr (slot),
        .wr_data (pix_reg),
        .rd_en   (cmd.byte_op == OPB_INDEX),
        .rd_addr (b[IDX_BITS-1:0]),
        .rd_data (ram_rd)
    );

    assign byte_stream.ready = cmd.accept;
    assign cfg.ready         = 1'b1;

    assign pixel_stream.valid      = out_valid_reg;
    assign pixel_stream.red        = out_pix_reg.red;
    assign pixel_stream.green      = out_pix_reg.green;
    assign pixel_stream.blue       = out_pix_reg.blue;
    assign pixel_stream.alpha      = out_pix_reg.alpha;
    assign pixel_stream.col_pos    = out_col_reg;
    assign pixel_stream.row_pos    = out_row_reg;
    assign pixel_stream.image_last = out_ilast_reg;
    assign pixel_stream.burst_last = out_blast_reg;
    assign pixel_stream.status     = out_status_reg;

    always_comb
    begin
        status.beat_valid = byte_stream.valid;
        status.eod        = byte_stream.end_of_data;
        status.tag        = classify(b);
        status.pending    = pend_reg;
        status.lit_done   = ((pend_reg == PEND_RGB) && (taken_reg >= 2'd2))
                            || ((pend_reg == PEND_RGBA) && (taken_reg >= 2'd3));
        status.image_done = done_reg;
        status.dims_zero  = (width_reg == '0) || (height_reg == '0);
        status.out_free   = !out_valid_reg || pixel_stream.ready;
        status.run_last   = (run_reg == '0);
        status.pix_last   = pix_last;
    end

    always_comb
    begin
        pend_next  = pend_reg;
        taken_next = taken_reg;
        luma_next  = luma_reg;
        pix_next   = pix_reg;
        col_next   = col_reg;
        row_next   = row_reg;
        done_next  = done_reg;
        run_next   = run_reg;
        valid_next = valid_reg;

        out_valid_next  = out_valid_reg && !pixel_stream.ready;
        out_pix_next    = out_pix_reg;
        out_col_next    = out_col_reg;
        out_row_next    = out_row_reg;
        out_ilast_next  = out_ilast_reg;
        out_blast_next  = out_blast_reg;
        out_status_next = out_status_reg;

        unique case (cmd.byte_op)
            OPB_TRUNC:
            begin
                done_next  = 1'b1;
                pend_next  = PEND_NONE;
                taken_next = 2'd0;
            end
            OPB_SET_RGB:
            begin
                pend_next  = PEND_RGB;
                taken_next = 2'd0;
            end
            OPB_SET_RGBA:
            begin
                pend_next  = PEND_RGBA;
                taken_next = 2'd0;
            end
            OPB_DIFF:
            begin
                pix_next.red   = pix_reg.red + {6'd0, b[5:4]} + 8'd254;
                pix_next.green = pix_reg.green + {6'd0, b[3:2]} + 8'd254;
                pix_next.blue  = pix_reg.blue + {6'd0, b[1:0]} + 8'd254;
            end
            OPB_LUMA_TAG:
            begin
                luma_next = b;
                pend_next = PEND_LUMA;
            end
            OPB_LUMA_DATA:
            begin
                pix_next.red   = pix_reg.red + {2'd0, dg} + {4'd0, b[7:4]} + 8'd216;
                pix_next.green = pix_reg.green + {2'd0, dg} + 8'd224;
                pix_next.blue  = pix_reg.blue + {2'd0, dg} + {4'd0, b[3:0]} + 8'd216;
                pend_next      = PEND_NONE;
            end
            OPB_LIT_DATA:
            begin
                unique case (taken_reg)
                    2'd0: pix_next.red   = b;
                    2'd1: pix_next.green = b;
                    2'd2: pix_next.blue  = b;
                    default: pix_next.alpha = b;
                endcase
                if (status.lit_done)
                begin
                    pend_next  = PEND_NONE;
                    taken_next = 2'd0;
                end
                else
                begin
                    taken_next = taken_reg + 2'd1;
                end
            end
            OPB_RUN: run_next = b[5:0];
            default:
            begin
            end
        endcase

        if (cmd.load_index)
        begin
            pix_next = rdv_reg ? pixel_t'(ram_rd) : '0;
        end

        if ((cmd.emit == EMIT_STORE) || (cmd.emit == EMIT_RUN))
        begin
            out_valid_next  = 1'b1;
            out_pix_next    = pix_reg;
            out_col_next    = col_ext[POS_W-1:0];
            out_row_next    = row_ext[POS_W-1:0];
            out_ilast_next  = pix_last;
            out_status_next = 1'b0;
            out_blast_next  = (cmd.emit == EMIT_STORE) || (run_reg == '0) || pix_last;
            if (cmd.emit == EMIT_STORE)
            begin
                valid_next[slot] = 1'b1;
            end
            else
            begin
                run_next = run_reg - 6'd1;
            end
            priority if (pix_last)
            begin
                done_next = 1'b1;
            end
            else if (col_end)
            begin
                col_next = '0;
                row_next = row_plus[DIM_BITS-1:0];
            end
            else
            begin
                col_next = col_plus[DIM_BITS-1:0];
            end
        end
        else if (cmd.emit == EMIT_TRUNC)
        begin
            out_valid_next  = 1'b1;
            out_pix_next    = '0;
            out_col_next    = '0;
            out_row_next    = '0;
            out_ilast_next  = 1'b0;
            out_blast_next  = 1'b1;
            out_status_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg     <= POS_W'(1);
            height_reg    <= POS_W'(1);
            pend_reg      <= PEND_NONE;
            taken_reg     <= 2'd0;
            luma_reg      <= 8'd0;
            pix_reg       <= '{red: 8'd0, green: 8'd0, blue: 8'd0, alpha: 8'd255};
            col_reg       <= '0;
            row_reg       <= '0;
            done_reg      <= 1'b0;
            run_reg       <= '0;
            valid_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg.valid && (cfg.index == CFG_IMAGE_WIDTH))
            begin
                width_reg <= cfg.data;
            end
            if (cfg.valid && (cfg.index == CFG_IMAGE_HEIGHT))
            begin
                height_reg <= cfg.data;
            end
            pend_reg      <= pend_next;
            taken_reg     <= taken_next;
            luma_reg      <= luma_next;
            pix_reg       <= pix_next;
            col_reg       <= col_next;
            row_reg       <= row_next;
            done_reg      <= done_next;
            run_reg       <= run_next;
            valid_reg     <= valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.byte_op == OPB_INDEX)
        begin
            rdv_reg <= valid_reg[b[IDX_BITS-1:0]];
        end
        out_pix_reg    <= out_pix_next;
        out_col_reg    <= out_col_next;
        out_row_reg    <= out_row_next;
        out_ilast_reg  <= out_ilast_next;
        out_blast_reg  <= out_blast_next;
        out_status_reg <= out_status_next;
    end
endmodule

// ===== design/qcsd_checker.sv =====
`timescale 1ns / 1ps
// Port-level checker for the QOI chunk stream decoder, bound to the top level.
module qcsd_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input logic [7:0]  red,
    input logic [7:0]  green,
    input logic [7:0]  blue,
    input logic [7:0]  alpha,
    input logic [15:0] col_pos,
    input logic [15:0] row_pos,
    input logic        image_last,
    input logic        burst_last,
    input logic        status
);
    a_trunc_alone: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status |-> burst_last && !image_last)
        else $error("truncation beat must end its burst and not mark the image end");

    a_trunc_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status |-> red == 8'd0 && green == 8'd0 && blue == 8'd0
            && alpha == 8'd0 && col_pos == 16'd0 && row_pos == 16'd0)
        else $error("truncation beat carries nonzero pixel fields");

    a_last_ends_burst: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && image_last |-> burst_last)
        else $error("final pixel of the image does not end its burst");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(col_pos) && $stable(row_pos)
            && $stable(status))
        else $error("stalled output beat changed or dropped");
endmodule

bind qoi_chunk_stream_decoder_unit qcsd_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .out_valid  (pixel_stream.valid),
    .out_ready  (pixel_stream.ready),
    .red        (pixel_stream.red),
    .green      (pixel_stream.green),
    .blue       (pixel_stream.blue),
    .alpha      (pixel_stream.alpha),
    .col_pos    (pixel_stream.col_pos),
    .row_pos    (pixel_stream.row_pos),
    .image_last (pixel_stream.image_last),
    .burst_last (pixel_stream.burst_last),
    .status     (pixel_stream.status)
);

// ===== verif/qoi_chunk_stream_decoder_unit_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench of the QOI chunk stream decoder: stream driver, pixel monitor, predictor.
module qoi_chunk_stream_decoder_unit_tb;
    import qcsd_pkg::*;

    localparam int SETTLE      = 8;
    localparam int IDLE_LIMIT  = 1000;
    localparam int RAND_PHASES = 6;
    localparam int PHASE_BYTES = 70;

    typedef struct packed {
        logic [7:0] data;
        logic       eod;
    } stream_beat_t;

    typedef struct packed {
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [7:0]  alpha;
        logic [15:0] col_pos;
        logic [15:0] row_pos;
        logic        image_last;
        logic        burst_last;
        logic        status;
    } pix_beat_t;

    logic clk;
    logic rst_n;

    qcsd_in_if  byte_ch ();
    qcsd_out_if pixel_ch ();
    qcsd_cfg_if cfg_ch ();

    qoi_chunk_stream_decoder_unit #(.DIM_BITS(16)) uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .byte_stream  (byte_ch),
        .pixel_stream (pixel_ch),
        .cfg          (cfg_ch)
    );

    // decoder state mirror
    pixel_t      cur_px;
    pixel_t      px_index [INDEX_ENTRIES];
    pend_t       pend;
    logic [1:0]  lit_cnt;
    logic [7:0]  luma_tag;
    logic [15:0] cur_col;
    logic [15:0] cur_row;
    logic [15:0] img_w;
    logic [15:0] img_h;
    logic        img_done;

    stream_beat_t stream_q [$];
    pix_beat_t    pixel_q [$];

    int  beats_total;
    int  beats_done;
    int  pix_checked;
    int  trunc_seen;
    int  cfg_writes;
    int  err_cnt;
    int  src_gap;
    int  snk_gap;
    int  idle_cycles;
    logic calm;

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 75)
            return $urandom_range(1, 3);
        else if (r < 95)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [5:0] px_slot(input pixel_t p);
        int h;
        h = 3 * p.red + 5 * p.green + 7 * p.blue + 11 * p.alpha;
        return h[5:0];
    endfunction

    task automatic emit_pixel();
        pix_beat_t e;
        logic      col_end;
        logic      last;
        col_end = (int'(cur_col) + 1 >= int'(img_w));
        last = col_end && (int'(cur_row) + 1 >= int'(img_h));
        e = '0;
        e.red = cur_px.red;
        e.green = cur_px.green;
        e.blue = cur_px.blue;
        e.alpha = cur_px.alpha;
        e.col_pos = cur_col;
        e.row_pos = cur_row;
        e.image_last = last;
        pixel_q.push_back(e);
        if (last)
            img_done = 1'b1;
        else if (col_end)
        begin
            cur_col = '0;
            cur_row = cur_row + 16'd1;
        end
        else
            cur_col = cur_col + 16'd1;
    endtask

    task automatic store_pixel();
        px_index[px_slot(cur_px)] = cur_px;
        emit_pixel();
    endtask

    task automatic predict_beat(input logic [7:0] b, input logic eod);
        int        queued;
        int        run_len;
        logic [5:0] dg;
        pix_beat_t e;
        queued = pixel_q.size();
        if (img_done || img_w == 16'd0 || img_h == 16'd0)
            return;
        if (eod)
        begin
            e = '0;
            e.burst_last = 1'b1;
            e.status = 1'b1;
            pixel_q.push_back(e);
            img_done = 1'b1;
            pend = PEND_NONE;
            lit_cnt = '0;
            return;
        end
        if (pend == PEND_NONE)
        begin
            if (b == QOI_OP_RGB)
            begin
                pend = PEND_RGB;
                lit_cnt = '0;
            end
            else if (b == QOI_OP_RGBA)
            begin
                pend = PEND_RGBA;
                lit_cnt = '0;
            end
            else
            begin
                case (b[7:6])
                    QOI_TAG_INDEX:
                    begin
                        cur_px = px_index[b[5:0]];
                        store_pixel();
                    end
                    QOI_TAG_DIFF:
                    begin
                        cur_px.red = cur_px.red + 8'(b[5:4]) - 8'd2;
                        cur_px.green = cur_px.green + 8'(b[3:2]) - 8'd2;
                        cur_px.blue = cur_px.blue + 8'(b[1:0]) - 8'd2;
                        store_pixel();
                    end
                    QOI_TAG_LUMA:
                    begin
                        luma_tag = b;
                        pend = PEND_LUMA;
                    end
                    default:
                    begin
                        run_len = int'(b[5:0]) + 1;
                        while (run_len > 0 && !img_done)
                        begin
                            emit_pixel();
                            run_len--;
                        end
                    end
                endcase
            end
        end
        else if (pend == PEND_LUMA)
        begin
            dg = luma_tag[5:0];
            cur_px.red = cur_px.red + 8'(dg) + 8'(b[7:4]) + 8'd216;
            cur_px.green = cur_px.green + 8'(dg) + 8'd224;
            cur_px.blue = cur_px.blue + 8'(dg) + 8'(b[3:0]) + 8'd216;
            pend = PEND_NONE;
            store_pixel();
        end
        else
        begin
            case (lit_cnt)
                2'd0: cur_px.red = b;
                2'd1: cur_px.green = b;
                2'd2: cur_px.blue = b;
                default: cur_px.alpha = b;
            endcase
            if ((pend == PEND_RGB && lit_cnt >= 2'd2) || (pend == PEND_RGBA && lit_cnt >= 2'd3))
            begin
                pend = PEND_NONE;
                lit_cnt = '0;
                store_pixel();
            end
            else
                lit_cnt = lit_cnt + 2'd1;
        end
        if (pixel_q.size() > queued)
        begin
            e = pixel_q.pop_back();
            e.burst_last = 1'b1;
            pixel_q.push_back(e);
        end
    endtask

    task automatic report_mismatch(input string msg);
        $display("[%0t] MISMATCH %s", $realtime, msg);
        err_cnt++;
    endtask

    task automatic cmp_field(input string name, input logic [15:0] got, input logic [15:0] want);
        if (got !== want)
            report_mismatch($sformatf("pixel beat %0d field %s: got %0h, want %0h",
                                      pix_checked, name, got, want));
    endtask

    always @(posedge clk)
    begin : stream_driver
        logic         valid_nx;
        stream_beat_t nb;
        if (!rst_n)
            byte_ch.valid <= 1'b0;
        else
        begin
            valid_nx = byte_ch.valid;
            if (byte_ch.valid && byte_ch.ready)
            begin
                predict_beat(byte_ch.data_byte, byte_ch.end_of_data);
                beats_done++;
                valid_nx = 1'b0;
            end
            if (!valid_nx)
            begin
                if (src_gap > 0)
                    src_gap--;
                else if (stream_q.size() > 0)
                begin
                    nb = stream_q.pop_front();
                    byte_ch.data_byte <= nb.data;
                    byte_ch.end_of_data <= nb.eod;
                    valid_nx = 1'b1;
                    if (!calm && $urandom_range(0, 99) < 30)
                        src_gap = pick_gap();
                end
            end
            byte_ch.valid <= valid_nx;
        end
    end

    always @(posedge clk)
    begin : pixel_monitor
        pix_beat_t got;
        pix_beat_t want;
        if (!rst_n)
            pixel_ch.ready <= 1'b0;
        else
        begin
            if (pixel_ch.valid && pixel_ch.ready)
            begin
                got.red = pixel_ch.red;
                got.green = pixel_ch.green;
                got.blue = pixel_ch.blue;
                got.alpha = pixel_ch.alpha;
                got.col_pos = pixel_ch.col_pos;
                got.row_pos = pixel_ch.row_pos;
                got.image_last = pixel_ch.image_last;
                got.burst_last = pixel_ch.burst_last;
                got.status = pixel_ch.status;
                if (pixel_q.size() == 0)
                    report_mismatch($sformatf("pixel beat with nothing expected: %p", got));
                else
                begin
                    want = pixel_q.pop_front();
                    cmp_field("red", 16'(got.red), 16'(want.red));
                    cmp_field("green", 16'(got.green), 16'(want.green));
                    cmp_field("blue", 16'(got.blue), 16'(want.blue));
                    cmp_field("alpha", 16'(got.alpha), 16'(want.alpha));
                    cmp_field("col_pos", got.col_pos, want.col_pos);
                    cmp_field("row_pos", got.row_pos, want.row_pos);
                    cmp_field("image_last", 16'(got.image_last), 16'(want.image_last));
                    cmp_field("burst_last", 16'(got.burst_last), 16'(want.burst_last));
                    cmp_field("status", 16'(got.status), 16'(want.status));
                    if (want.status)
                        trunc_seen++;
                end
                pix_checked++;
            end
            if (snk_gap > 0)
            begin
                snk_gap--;
                pixel_ch.ready <= 1'b0;
            end
            else
            begin
                pixel_ch.ready <= 1'b1;
                if (!calm && $urandom_range(0, 99) < 15)
                    snk_gap = pick_gap();
            end
        end
    end

    always @(posedge clk)
    begin : watchdog
        if (!rst_n || (byte_ch.valid && byte_ch.ready) || (pixel_ch.valid && pixel_ch.ready)
            || (cfg_ch.valid && cfg_ch.ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("watchdog: no beat for %0d cycles, %0d pixels still owed",
                     idle_cycles, pixel_q.size());
            $display("qoi_chunk_stream_decoder_unit_tb: done, errors");
            $finish;
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
        @(posedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data <= val;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        if (idx == CFG_IMAGE_WIDTH)
            img_w = val;
        else if (idx == CFG_IMAGE_HEIGHT)
            img_h = val;
        cfg_writes++;
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic push_beat(input logic [7:0] b, input logic eod);
        stream_beat_t sb;
        sb.data = b;
        sb.eod = eod;
        stream_q.push_back(sb);
        beats_total++;
    endtask

    task automatic push_run(input int copies);
        push_beat({QOI_TAG_RUN, 6'(copies - 1)}, 1'b0);
    endtask

    task automatic push_chunk();
        int kind;
        int n;
        kind = $urandom_range(0, 99);
        if (kind < 12)
        begin
            push_beat(QOI_OP_RGB, 1'b0);
            repeat (3) push_beat(8'($urandom_range(0, 255)), 1'b0);
        end
        else if (kind < 22)
        begin
            push_beat(QOI_OP_RGBA, 1'b0);
            repeat (4) push_beat(8'($urandom_range(0, 255)), 1'b0);
        end
        else if (kind < 40)
            push_beat({QOI_TAG_INDEX, 6'($urandom_range(0, 63))}, 1'b0);
        else if (kind < 60)
            push_beat({QOI_TAG_DIFF, 6'($urandom_range(0, 63))}, 1'b0);
        else if (kind < 78)
        begin
            push_beat({QOI_TAG_LUMA, 6'($urandom_range(0, 63))}, 1'b0);
            push_beat(8'($urandom_range(0, 255)), 1'b0);
        end
        else if (kind < 90)
        begin
            n = ($urandom_range(0, 9) < 7) ? $urandom_range(1, 8) : $urandom_range(9, 62);
            push_run(n);
        end
        else
            push_beat(8'($urandom_range(0, 255)), 1'b0);
    endtask

    task automatic drain();
        while (beats_done != beats_total || pixel_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    initial
    begin
        int    start;
        int    w;
        int    sel;
        string ending;
        rst_n = 1'b0;
        byte_ch.valid = 1'b0;
        byte_ch.data_byte = '0;
        byte_ch.end_of_data = 1'b0;
        pixel_ch.ready = 1'b0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = '0;
        cfg_ch.data = '0;
        calm = 1'b0;
        src_gap = 0;
        snk_gap = 0;
        idle_cycles = 0;
        beats_total = 0;
        beats_done = 0;
        pix_checked = 0;
        trunc_seen = 0;
        cfg_writes = 0;
        err_cnt = 0;
        img_w = 16'd1;
        img_h = 16'd1;
        pend = PEND_NONE;
        lit_cnt = '0;
        luma_tag = '0;
        cur_px = '{red: 8'd0, green: 8'd0, blue: 8'd0, alpha: 8'd255};
        foreach (px_index[i])
            px_index[i] = '0;
        cur_col = '0;
        cur_row = '0;
        img_done = 1'b0;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // zero-sized image: everything dropped, end of data too
        write_reg(CFG_IMAGE_WIDTH, 16'd0);
        push_beat(QOI_OP_RGBA, 1'b0);
        push_run(62);
        push_beat(8'h5a, 1'b1);
        push_beat({QOI_TAG_DIFF, 6'h2a}, 1'b0);
        drain();
        write_reg(CFG_IMAGE_WIDTH, 16'hffff);
        write_reg(CFG_IMAGE_HEIGHT, 16'd0);
        push_beat({QOI_TAG_LUMA, 6'h15}, 1'b0);
        push_beat(8'ha5, 1'b1);
        push_beat(8'h00, 1'b0);
        drain();
        write_reg(CFG_IMAGE_HEIGHT, 16'hffff);

        // every chunk kind at its extremes
        push_beat(QOI_OP_RGB, 1'b0);
        push_beat(8'h00, 1'b0);
        push_beat(8'hff, 1'b0);
        push_beat(8'h80, 1'b0);
        push_beat(QOI_OP_RGBA, 1'b0);
        push_beat(8'h12, 1'b0);
        push_beat(8'h34, 1'b0);
        push_beat(8'h56, 1'b0);
        push_beat(8'h00, 1'b0);
        push_beat(QOI_OP_RGBA, 1'b0);
        repeat (4) push_beat(8'hff, 1'b0);
        push_beat({QOI_TAG_INDEX, 6'h00}, 1'b0);
        push_beat({QOI_TAG_INDEX, 6'h3f}, 1'b0);
        push_beat({QOI_TAG_DIFF, 6'h00}, 1'b0);
        push_beat({QOI_TAG_DIFF, 6'h3f}, 1'b0);
        push_beat({QOI_TAG_DIFF, 6'h2a}, 1'b0);
        push_beat({QOI_TAG_LUMA, 6'h00}, 1'b0);
        push_beat(8'h00, 1'b0);
        push_beat({QOI_TAG_LUMA, 6'h3f}, 1'b0);
        push_beat(8'hff, 1'b0);
        push_run(1);
        push_run(62);
        drain();

        for (int ph = 0; ph < RAND_PHASES; ph++)
        begin
            if (ph == 0)
                w = 1;
            else if (ph == 1)
                w = 65535;
            else if ($urandom_range(0, 1) == 0)
                w = $urandom_range(2, 40);
            else
                w = $urandom_range(1, 65535);
            write_reg(CFG_IMAGE_WIDTH, 16'(w));
            if (ph >= 2 && $urandom_range(0, 1) == 0)
                write_reg(CFG_IMAGE_HEIGHT, 16'($urandom_range(int'(cur_row) + 2, 65535)));
            calm = (ph == 2) || ($urandom_range(0, 4) == 0);
            start = beats_total;
            while (beats_total - start < PHASE_BYTES)
                push_chunk();
            drain();
        end
        calm = 1'b0;

        if ($urandom_range(0, 1) == 0)
        begin
            ending = "image end";
            write_reg(CFG_IMAGE_WIDTH, 16'($urandom_range(1, 8)));
            write_reg(CFG_IMAGE_HEIGHT, 16'd1);
            push_run(62);
            start = beats_total;
            while (beats_total - start < 12)
                push_chunk();
            push_beat(8'($urandom_range(0, 255)), 1'b1);
        end
        else
        begin
            ending = "truncated stream";
            start = beats_total;
            while (beats_total - start < 10)
                push_chunk();
            sel = $urandom_range(0, 2);
            if (sel == 1)
            begin
                push_beat(QOI_OP_RGBA, 1'b0);
                repeat ($urandom_range(0, 3)) push_beat(8'($urandom_range(0, 255)), 1'b0);
            end
            else if (sel == 2)
                push_beat({QOI_TAG_LUMA, 6'($urandom_range(0, 63))}, 1'b0);
            push_beat(8'($urandom_range(0, 255)), 1'b1);
        end
        repeat (6) push_beat(8'($urandom_range(0, 255)), 1'b0);
        drain();

        $display("covered %0d stream bytes and %0d register writes, ending with %s",
                 beats_total, cfg_writes, ending);
        $display("checked %0d pixel beats (%0d truncation), %0d mismatches",
                 pix_checked, trunc_seen, err_cnt);
        if (err_cnt == 0)
            $display("qoi_chunk_stream_decoder_unit_tb: done, clean");
        else
            $display("qoi_chunk_stream_decoder_unit_tb: done, errors");
        $finish;
    end

endmodule
